// File: rtl/rvq_pkg.sv
// ----------------------------------------------------------------------------
// rvq_pkg
// Types, codes and constants shared by the sorted run queue modules.
// ----------------------------------------------------------------------------
package rvq_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned RT_W      = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned TICK_W    = 20;
  localparam int unsigned QCNT_W    = 7;

  localparam logic [1:0]        NICE_DEF   = 2'd3;
  localparam logic [TICK_W-1:0] TICKS_ZERO = TICK_W'(10);
  localparam logic [3:0]        WEIGHT_N1  = 4'd10;
  localparam logic [3:0]        WEIGHT_N2  = 4'd7;
  localparam logic [3:0]        WEIGHT_N3  = 4'd5;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_WAKE    = 3'd1,
    CMD_CHARGE  = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_PICK    = 3'd4,
    CMD_SETNICE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2,
    ST_BADNICE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EXEC,
    FSM_DIV,
    FSM_RIPPLE,
    FSM_INSERT,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic              align_to_head;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [2:0]        new_nice;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] picked_slot;
    logic [RT_W-1:0]   slot_runtime;
    logic [QCNT_W-1:0] queue_count;
  } out_t;

  // One entry of the sorted chain.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [RT_W-1:0]   key;
  } cell_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              rem;
    logic              shift;
    logic [SLOT_W-1:0] slot;
    logic [RT_W-1:0]   key;
  } cell_ctrl_t;

  function automatic logic [3:0] weight_of(input logic [1:0] n);
    case (n)
      2'd1:    weight_of = WEIGHT_N1;
      2'd2:    weight_of = WEIGHT_N2;
      default: weight_of = WEIGHT_N3;
    endcase
  endfunction

endpackage

// File: rtl/rvq_cell.sv
// ----------------------------------------------------------------------------
// rvq_cell
// One position of the sorted queue: holds a slot and its key, inserts in
// place by a local compare, and closes a hole by taking its right neighbor.
// ----------------------------------------------------------------------------
module rvq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rvq_pkg::cell_ctrl_t ctrl_i,
  input  logic               is_head_i,
  input  logic               prev_le_i,
  input  rvq_pkg::cell_t     prev_i,
  input  rvq_pkg::cell_t     next_i,
  input  logic               hole_prev_i,
  output logic               le_o,
  output logic               hole_o,
  output rvq_pkg::cell_t     cell_o
);
  import rvq_pkg::*;

  cell_t cell_q, cell_d;
  logic  hole_q, hole_d;

  // Entries ahead of the insertion point hold their key at or below the new one.
  assign le_o   = cell_q.valid && (cell_q.key <= ctrl_i.key);
  assign hole_o = hole_q;
  assign cell_o = cell_q;

  always_comb begin
    cell_d = cell_q;
    hole_d = hole_q;
    if (ctrl_i.ins) begin
      if (!le_o) begin
        if (prev_le_i) begin
          cell_d = '{valid: 1'b1, slot: ctrl_i.slot, key: ctrl_i.key};
        end else begin
          cell_d = prev_i;
        end
      end
    end else if (ctrl_i.shift) begin
      if (hole_q) begin
        cell_d = next_i;
      end
      hole_d = hole_prev_i;
    end else if ((ctrl_i.pop && is_head_i) ||
                 (ctrl_i.rem && cell_q.valid && (cell_q.slot == ctrl_i.slot))) begin
      hole_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
      hole_q <= 1'b0;
    end else begin
      cell_q <= cell_d;
      hole_q <= hole_d;
    end
  end

endmodule

// File: rtl/rvq_div.sv
// ----------------------------------------------------------------------------
// rvq_div
// Restoring divider of the runtime by a small weight, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rvq_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rvq_pkg::RT_W-1:0] dividend_i,
  input  logic [3:0]               divisor_i,
  output logic                     done_o,
  output logic [rvq_pkg::RT_W-1:0] quot_o
);
  import rvq_pkg::*;

  localparam int unsigned CNT_W = $clog2(RT_W + 1);

  logic [RT_W-1:0]  quot_q, quot_d;
  logic [3:0]       rem_q, rem_d, dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [4:0]       trial;

  assign trial  = {rem_q, quot_q[RT_W-1]};
  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = quot_d;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(RT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 4'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[RT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[3:0];
        quot_d = {quot_q[RT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

endmodule

// File: rtl/vruntime_sorted_run_queue_unit.sv
// ----------------------------------------------------------------------------
// vruntime_sorted_run_queue_unit
// Fair-share run queue: per-slot runtime and nice table plus a chain of cells
// that keeps the queued slots sorted by virtual runtime.
//
//   channel  direction  signals                           payload
//   in       input      in_valid_i / in_stall_o           rvq_pkg::in_t
//   out      output     out_valid_o / out_stall_i         rvq_pkg::out_t
//
// One item at a time. Create, wake and charge pass the read, execute and
// insert states; remove and pick walk the hole along the chain one cell a cycle;
// a new nice level runs the bit-serial divider, then re-sorts a queued slot.
// Reset is asynchronous; the table reads as runtime 0, nice 3 until written.
// A waiting result never blocks the next item; a finished item waits for the
// output register only if the previous result is still stalled.
// ----------------------------------------------------------------------------
module vruntime_sorted_run_queue_unit #(
  parameter int unsigned SLOTS = rvq_pkg::SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rvq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rvq_pkg::out_t out_data_o
);
  import rvq_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  fsm_e state_q, state_d;

  in_t            cmd_q;
  logic [SW-1:0]  idx_q;
  logic           inside_q;
  logic [CW-1:0]  cnt_q;
  logic [SLOTS-1:0] mark_q, written_q;
  logic           wbit_q;
  logic [CW-1:0]  rip_q;
  logic           after_ins_q, reins_q;
  logic [1:0]     res_status_q;
  logic [SLOT_W-1:0] res_shown_q;
  logic [RT_W-1:0] rt_q;
  logic           out_valid_q;
  out_t           out_q;

  // Slot table: nice level over runtime.
  logic [RT_W+1:0] mem_q [SLOTS];
  logic [RT_W+1:0] rd_q;

  logic          accept;
  logic [SW+SLOT_W-1:0] in_wide, head_wide;
  logic [SW-1:0] in_idx, head_idx;
  logic          in_inside;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_wide   = {SW'(0), in_data_i.slot};
  assign in_idx    = in_wide[SW-1:0];
  assign in_inside = in_wide < (SW+SLOT_W)'(SLOTS);

  // Cell chain.
  cell_ctrl_t ctrl;
  cell_t      cells [SLOTS];
  logic [SLOTS-1:0] le, hole;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rvq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .is_head_i   (i == 0),
      .prev_le_i   ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1]),
      .prev_i      (cells[(i == 0) ? 0 : i-1]),
      .next_i      ((i == SLOTS-1) ? cell_t'('0) : cells[(i == SLOTS-1) ? i : i+1]),
      .hole_prev_i ((i == 0) ? 1'b0 : hole[(i == 0) ? 0 : i-1]),
      .le_o        (le[i]),
      .hole_o      (hole[i]),
      .cell_o      (cells[i])
    );
  end

  assign head_wide = {SW'(0), cells[0].slot};
  assign head_idx  = head_wide[SW-1:0];

  // Divider for the nice rescale.
  logic            div_start, div_done;
  logic [RT_W-1:0] div_quot, div_dividend;
  logic [3:0]      div_divisor;

  rvq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Current slot values, defaulted where the entry was never written.
  logic [RT_W-1:0]   rt_cur;
  logic [1:0]        nice_cur;
  logic              q_cur;
  logic [TICK_W-1:0] ticks_eff;
  logic [TICK_W+1:0] charge_add;
  logic [RT_W-1:0]   head_key;
  logic              nonempty;

  assign rt_cur     = wbit_q ? rd_q[RT_W-1:0] : '0;
  assign nice_cur   = wbit_q ? rd_q[RT_W+1:RT_W] : NICE_DEF;
  assign q_cur      = mark_q[idx_q];
  assign ticks_eff  = (cmd_q.elapsed_ticks == '0) ? TICKS_ZERO : cmd_q.elapsed_ticks;
  assign charge_add = {2'b00, ticks_eff} * {TICK_W'(0), nice_cur};
  assign head_key   = cells[0].key;
  assign nonempty   = (cnt_q != '0);

  always_comb begin
    case (weight_of(nice_cur))
      WEIGHT_N1: div_dividend = (rt_cur << 3) + (rt_cur << 1);
      WEIGHT_N2: div_dividend = (rt_cur << 3) - rt_cur;
      default:   div_dividend = (rt_cur << 2) + rt_cur;
    endcase
  end
  assign div_divisor = weight_of(cmd_q.new_nice[1:0]);

  // Command decode in the execute cycle.
  logic [1:0]      x_status;
  logic [SLOT_W-1:0] x_shown;
  logic [RT_W-1:0] x_rt;
  logic            x_we, x_pop, x_rem, x_clr, x_div;
  logic [RT_W+1:0] x_wd;
  fsm_e            x_next;

  always_comb begin
    x_status = ST_OK;
    x_shown  = cmd_q.slot;
    x_rt     = rt_cur;
    x_we     = 1'b0;
    x_wd     = {nice_cur, rt_cur};
    x_pop    = 1'b0;
    x_rem    = 1'b0;
    x_clr    = 1'b0;
    x_div    = 1'b0;
    x_next   = FSM_DONE;
    if (cmd_e'(cmd_q.cmd) == CMD_PICK) begin
      if (!nonempty) begin
        x_status = ST_EMPTY;
        x_rt     = '0;
      end else begin
        x_shown = cells[0].slot;
        x_rt    = head_key;
        x_pop   = 1'b1;
        x_clr   = 1'b1;
        x_next  = FSM_RIPPLE;
      end
    end else if (!inside_q) begin
      x_status = ST_IGNORED;
      x_rt     = '0;
    end else begin
      case (cmd_e'(cmd_q.cmd))
        CMD_CREATE, CMD_WAKE, CMD_CHARGE: begin
          if (q_cur) begin
            x_status = ST_IGNORED;
          end else begin
            if (cmd_e'(cmd_q.cmd) == CMD_CREATE) begin
              x_rt = nonempty ? head_key : '0;
              x_wd = {NICE_DEF, x_rt};
            end else if (cmd_e'(cmd_q.cmd) == CMD_WAKE) begin
              if (cmd_q.align_to_head && nonempty && (head_key < rt_cur)) begin
                x_rt = head_key;
              end
              x_wd = {nice_cur, x_rt};
            end else begin
              x_rt = rt_cur + RT_W'(charge_add);
              x_wd = {nice_cur, x_rt};
            end
            x_we   = 1'b1;
            x_next = FSM_INSERT;
          end
        end
        CMD_REMOVE: begin
          if (!q_cur) begin
            x_status = ST_IGNORED;
          end else begin
            x_rem  = 1'b1;
            x_clr  = 1'b1;
            x_next = FSM_RIPPLE;
          end
        end
        CMD_SETNICE: begin
          if ((cmd_q.new_nice == 3'd0) || (cmd_q.new_nice > 3'd3)) begin
            x_status = ST_BADNICE;
          end else if (cmd_q.new_nice[1:0] != nice_cur) begin
            x_div  = 1'b1;
            x_next = FSM_DIV;
          end
        end
        default: x_status = ST_IGNORED;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (accept) state_d = FSM_READ;
      FSM_READ:   state_d = FSM_EXEC;
      FSM_EXEC:   state_d = x_next;
      FSM_DIV: begin
        if (div_done) state_d = q_cur ? FSM_RIPPLE : FSM_DONE;
      end
      FSM_RIPPLE: begin
        if (rip_q == '0) state_d = after_ins_q ? FSM_INSERT : FSM_DONE;
      end
      FSM_INSERT: state_d = FSM_DONE;
      FSM_DONE:   if (!out_valid_q || !out_stall_i) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // Controls per state.
  logic            mem_we;
  logic [RT_W+1:0] mem_wd;
  logic            mark_clr, mark_set, cnt_dec, cnt_inc, res_ld, rip_ld;
  logic            rt_ld, after_set, out_ld;
  logic [RT_W-1:0] rt_new;
  logic [SW-1:0]   mark_idx;

  always_comb begin
    ctrl      = '{ins: 1'b0, pop: 1'b0, rem: 1'b0, shift: 1'b0,
                  slot: cmd_q.slot, key: rt_q};
    mem_we    = 1'b0;
    mem_wd    = x_wd;
    mark_clr  = 1'b0;
    mark_set  = 1'b0;
    mark_idx  = idx_q;
    cnt_dec   = 1'b0;
    cnt_inc   = 1'b0;
    res_ld    = 1'b0;
    rt_ld     = 1'b0;
    rt_new    = x_rt;
    rip_ld    = 1'b0;
    after_set = 1'b0;
    div_start = 1'b0;
    out_ld    = 1'b0;
    case (state_q)
      FSM_EXEC: begin
        res_ld    = 1'b1;
        rt_ld     = 1'b1;
        mem_we    = x_we;
        ctrl.pop  = x_pop;
        ctrl.rem  = x_rem;
        mark_clr  = x_clr;
        mark_idx  = x_pop ? head_idx : idx_q;
        cnt_dec   = x_clr;
        rip_ld    = x_pop || x_rem;
        div_start = x_div;
      end
      FSM_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wd    = {cmd_q.new_nice[1:0], div_quot};
          rt_ld     = 1'b1;
          rt_new    = div_quot;
          ctrl.rem  = q_cur;
          rip_ld    = q_cur;
          after_set = q_cur;
        end
      end
      FSM_RIPPLE: ctrl.shift = 1'b1;
      FSM_INSERT: begin
        ctrl.ins = 1'b1;
        mark_set = 1'b1;
        cnt_inc  = !reins_q;
      end
      FSM_DONE: out_ld = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  logic [CW+QCNT_W-1:0] cnt_wide;
  assign cnt_wide = {QCNT_W'(0), cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      mark_q      <= '0;
      written_q   <= '0;
      rip_q       <= '0;
      after_ins_q <= 1'b0;
      reins_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (mark_clr) mark_q[mark_idx] <= 1'b0;
      if (mark_set) mark_q[mark_idx] <= 1'b1;
      if (mem_we) written_q[idx_q] <= 1'b1;
      if (rip_ld) begin
        rip_q <= CW'(SLOTS - 1);
      end else if (ctrl.shift && (rip_q != '0)) begin
        rip_q <= rip_q - CW'(1);
      end
      if (accept) begin
        after_ins_q <= 1'b0;
        reins_q     <= 1'b0;
      end else if (after_set) begin
        after_ins_q <= 1'b1;
        reins_q     <= 1'b1;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i;
      idx_q    <= in_idx;
      inside_q <= in_inside;
      wbit_q   <= written_q[in_idx];
      rd_q     <= mem_q[in_idx];
    end
    if (mem_we) begin
      mem_q[idx_q] <= mem_wd;
    end
    if (res_ld) begin
      res_status_q <= x_status;
      res_shown_q  <= x_shown;
    end
    if (rt_ld) begin
      rt_q <= rt_new;
    end
    if (out_ld) begin
      out_q <= '{status: res_status_q, picked_slot: res_shown_q,
                 slot_runtime: rt_q, queue_count: cnt_wide[QCNT_W-1:0]};
    end
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never passes the table size.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS)) else $error("queue count above table size");

  // Queued marks agree with the count whenever the block is idle.
  a_mark_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |-> ($countones(mark_q) == 32'(cnt_q)))
    else $error("queued marks disagree with count");

  // The head cell is occupied exactly when the queue is not empty.
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE) |-> (cells[0].valid == (cnt_q != '0)))
    else $error("head cell disagrees with count");

  // An accepted item always goes to the table read first.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FSM_READ)) else $error("accepted item not read");

endmodule
